@@ rtl/cfft_pkg.sv @@
// Shared types, constants and elaboration-time helpers for the radix-2 FFT.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package cfft_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int TW_FRAC_DEF      = 17;
  localparam int DATA_WIDTH       = 40;
  localparam int ANG_FRAC         = 28;
  localparam longint unsigned TWO_PI_ANG = 64'd1686629713;

  localparam int CFG_DATA_WIDTH = 4;
  localparam logic CFG_POINTS_LOG2 = 1'b0;
  localparam logic CFG_INVERSE     = 1'b1;
  localparam logic [3:0] POINTS_LOG2_RESET = 4'd10;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef enum logic {
    PH_LOADING = 1'b0,
    PH_READY   = 1'b1
  } phase_t;

  typedef enum logic [2:0] {
    WR_SAMPLE = 3'd0,
    WR_DOUT   = 3'd1,
    WR_OPA    = 3'd2,
    WR_SUM_HI = 3'd3,
    WR_SUM_LO = 3'd4,
    WR_SCALED = 3'd5
  } wr_sel_t;

  typedef struct packed {
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    lat_a;
    logic    mul_en;
    logic    sum_en;
    logic    inv;
    logic    out_zero;
  } dp_ctrl_t;

  // Saturate a widened sum to the data width
  function automatic logic signed [DATA_WIDTH-1:0] sat_data(
      input logic signed [DATA_WIDTH+3:0] v);
    logic signed [DATA_WIDTH+3:0] hi;
    logic signed [DATA_WIDTH+3:0] lo;
    hi = (DATA_WIDTH+4)'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[DATA_WIDTH-1:0];
    if (v < lo) return lo[DATA_WIDTH-1:0];
    return v[DATA_WIDTH-1:0];
  endfunction

  // Elaboration only: Q.28 rounded multiply
  function automatic longint unsigned mulq(input longint unsigned a,
                                           input longint unsigned b);
    return (a * b + (64'd1 << (ANG_FRAC - 1))) >> ANG_FRAC;
  endfunction

  // Elaboration only: truncating unsigned quotient, shift and subtract
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Elaboration only: Taylor series for cos or sin at Q.28 angle x
  function automatic longint taylor(input longint unsigned x, input bit want_sin);
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint cc;
    ts = x;
    tc = 64'd1 << ANG_FRAC;
    ss = longint'(x);
    cc = longint'(tc);
    for (int n = 1; n <= 12; n++) begin
      ts = udiv(mulq(mulq(ts, x), x), longint'((2 * n) * (2 * n + 1)));
      tc = udiv(mulq(mulq(tc, x), x), longint'((2 * n - 1) * (2 * n)));
      if ((n & 1) == 1) begin
        ss = ss - longint'(ts);
        cc = cc - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cc = cc + longint'(tc);
      end
    end
    return want_sin ? ss : cc;
  endfunction

  // Elaboration only: rounded arithmetic shift
  function automatic longint round_shr(input longint v, input int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

endpackage

@@ rtl/cfft_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module cfft_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/cfft_dp.sv @@
// FFT datapath: sample store, twiddle ROM, butterfly and inverse scaling.
// Depends on cfft_pkg and cfft_ram.
`timescale 1ns / 1ps
module cfft_dp #(
  parameter int MAX_POINTS        = cfft_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH      = cfft_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_FRAC_BITS = cfft_pkg::TW_FRAC_DEF,
  localparam int AW  = $clog2(MAX_POINTS),
  localparam int LW  = $clog2(AW + 1),
  localparam int TWA = (AW > 1) ? AW - 1 : 1
) (
  input  logic                                clk,
  input  cfft_pkg::dp_ctrl_t                  ctrl,
  input  logic [AW-1:0]                       rd_addr,
  input  logic [AW-1:0]                       wr_addr,
  input  logic [TWA-1:0]                      tw_idx,
  input  logic [LW-1:0]                       scale_shift,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_imag,
  output logic signed [cfft_pkg::DATA_WIDTH-1:0] result_real,
  output logic signed [cfft_pkg::DATA_WIDTH-1:0] result_imag
);

  localparam int DW   = cfft_pkg::DATA_WIDTH;
  localparam int TWW  = TWIDDLE_FRAC_BITS + 2;
  localparam int PW   = DW + TWW;
  localparam int HALF = MAX_POINTS / 2;

  typedef logic signed [TWW-1:0] rom_t [HALF];

  function automatic rom_t build_rom(input bit want_sin);
    rom_t r;
    longint unsigned j;
    longint unsigned x;
    longint v;
    bit mirror;
    for (int k = 0; k < HALF; k++) begin
      mirror = k > MAX_POINTS / 4;
      j = mirror ? longint'(MAX_POINTS / 2 - k) : longint'(k);
      x = (j * cfft_pkg::TWO_PI_ANG + longint'(MAX_POINTS / 2)) >> AW;
      v = cfft_pkg::round_shr(cfft_pkg::taylor(x, want_sin),
                              cfft_pkg::ANG_FRAC - TWIDDLE_FRAC_BITS);
      if (!want_sin && mirror) v = -v;
      r[k] = v[TWW-1:0];
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom(1'b0);
  localparam rom_t SIN_ROM = build_rom(1'b1);

  function automatic logic signed [DW+1:0] round_prod(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    logic signed [PW:0] sh;
    t  = {p[PW-1], p} + ((PW+1)'(1) <<< (TWIDDLE_FRAC_BITS - 1));
    sh = t >>> TWIDDLE_FRAC_BITS;
    return sh[DW+1:0];
  endfunction

  function automatic logic signed [DW-1:0] scale(input logic signed [DW-1:0] v,
                                                 input logic [LW-1:0] s);
    logic signed [DW:0] t;
    logic signed [DW:0] sh;
    t = {v[DW-1], v};
    if (s != '0) t = t + ((DW+1)'(1) <<< (s - LW'(1)));
    sh = t >>> s;
    return sh[DW-1:0];
  endfunction

  logic [2*DW-1:0] rd_data;
  logic [2*DW-1:0] wr_data;
  logic signed [DW-1:0] dout_re, dout_im;
  logic signed [DW-1:0] a_re, a_im;
  logic signed [TWW-1:0] tw_c, tw_s;
  logic signed [PW-1:0] p_cr, p_ci, p_sr, p_si;
  logic signed [DW-1:0] hi_re, hi_im, lo_re, lo_im;
  logic signed [DW+1:0] cr, ci, sr, si;
  logic signed [DW+3:0] tr, ti;

  assign dout_re = rd_data[2*DW-1:DW];
  assign dout_im = rd_data[DW-1:0];

  cfft_ram #(.WIDTH(2 * DW), .DEPTH(MAX_POINTS)) u_store (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    cr = round_prod(p_cr);
    ci = round_prod(p_ci);
    sr = round_prod(p_sr);
    si = round_prod(p_si);
    if (ctrl.inv) begin
      tr = (DW+4)'(cr) - (DW+4)'(si);
      ti = (DW+4)'(ci) + (DW+4)'(sr);
    end else begin
      tr = (DW+4)'(cr) + (DW+4)'(si);
      ti = (DW+4)'(ci) - (DW+4)'(sr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.lat_a) begin
      a_re <= dout_re;
      a_im <= dout_im;
      tw_c <= COS_ROM[tw_idx];
      tw_s <= SIN_ROM[tw_idx];
    end
    if (ctrl.mul_en) begin
      p_cr <= PW'(tw_c) * PW'(dout_re);
      p_ci <= PW'(tw_c) * PW'(dout_im);
      p_sr <= PW'(tw_s) * PW'(dout_re);
      p_si <= PW'(tw_s) * PW'(dout_im);
    end
    if (ctrl.sum_en) begin
      hi_re <= cfft_pkg::sat_data((DW+4)'(a_re) + tr);
      hi_im <= cfft_pkg::sat_data((DW+4)'(a_im) + ti);
      lo_re <= cfft_pkg::sat_data((DW+4)'(a_re) - tr);
      lo_im <= cfft_pkg::sat_data((DW+4)'(a_im) - ti);
    end
  end

  always_comb begin
    case (ctrl.wr_sel)
      cfft_pkg::WR_SAMPLE: wr_data = {DW'(sample_real), DW'(sample_imag)};
      cfft_pkg::WR_DOUT:   wr_data = rd_data;
      cfft_pkg::WR_OPA:    wr_data = {a_re, a_im};
      cfft_pkg::WR_SUM_HI: wr_data = {hi_re, hi_im};
      cfft_pkg::WR_SUM_LO: wr_data = {lo_re, lo_im};
      cfft_pkg::WR_SCALED: wr_data = {scale(dout_re, scale_shift),
                                      scale(dout_im, scale_shift)};
      default:             wr_data = rd_data;
    endcase
  end

  assign result_real = ctrl.out_zero ? '0 : dout_re;
  assign result_imag = ctrl.out_zero ? '0 : dout_im;

endmodule

@@ rtl/cfft_ctrl.sv @@
// FFT controller: config registers, frame phase, load/read indexes and the
// bit-reverse, butterfly and scaling sequencer. Depends on cfft_pkg.
`timescale 1ns / 1ps
module cfft_ctrl #(
  parameter int MAX_POINTS = cfft_pkg::MAX_POINTS_DEF,
  localparam int AW  = $clog2(MAX_POINTS),
  localparam int LW  = $clog2(AW + 1),
  localparam int TWA = (AW > 1) ? AW - 1 : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                func,
  output logic                                busy,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [cfft_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  output logic                                result_valid,
  output logic                                last_result,
  output logic                                status,
  output cfft_pkg::dp_ctrl_t                  ctrl,
  output logic [AW-1:0]                       rd_addr,
  output logic [AW-1:0]                       wr_addr,
  output logic [TWA-1:0]                      tw_idx,
  output logic [LW-1:0]                       scale_shift
);

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_BR_A = 13'h0002,
    S_BR_B = 13'h0004,
    S_BR_C = 13'h0008,
    S_BR_D = 13'h0010,
    S_BF_A = 13'h0020,
    S_BF_B = 13'h0040,
    S_BF_C = 13'h0080,
    S_BF_D = 13'h0100,
    S_BF_E = 13'h0200,
    S_BF_F = 13'h0400,
    S_SC_A = 13'h0800,
    S_SC_B = 13'h1000
  } state_t;

  state_t state, state_next;
  logic [3:0] points_log2, points_log2_next;
  logic inverse_mode, inverse_mode_next;
  cfft_pkg::phase_t phase, phase_next;
  logic [AW:0] load_index, load_index_next;
  logic [AW:0] read_index, read_index_next;
  logic [AW-1:0] idx, idx_next;
  logic [LW-1:0] st0, st0_next;
  logic result_valid_next, last_result_next, status_next;
  logic out_zero, out_zero_next;

  logic [LW-1:0] len_log2;
  logic [AW:0] n_pts;
  logic [AW-1:0] n_m1, half_m1, rev_full, rev, mask, ia, ja;
  logic accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign scale_shift = len_log2;

  always_comb begin
    len_log2 = (points_log2 > 4'(AW)) ? LW'(AW) : points_log2[LW-1:0];
    n_pts    = (AW+1)'(1) << len_log2;
    n_m1     = AW'(n_pts - (AW+1)'(1));
    half_m1  = AW'((n_pts >> 1) - (AW+1)'(1));
    for (int b = 0; b < AW; b++) rev_full[b] = idx[AW-1-b];
    rev  = rev_full >> (LW'(AW) - len_log2);
    mask = (AW'(1) << st0) - AW'(1);
    ia   = ((idx & ~mask) << 1) | (idx & mask);
    ja   = ia | (AW'(1) << st0);
    tw_idx = TWA'((idx & mask) << (LW'(AW - 1) - st0));
  end

  always_comb begin
    state_next        = state;
    points_log2_next  = points_log2;
    inverse_mode_next = inverse_mode;
    phase_next        = phase;
    load_index_next   = load_index;
    read_index_next   = read_index;
    idx_next          = idx;
    st0_next          = st0;
    result_valid_next = 1'b0;
    last_result_next  = 1'b0;
    status_next       = cfft_pkg::STATUS_OK;
    out_zero_next     = out_zero;
    rd_addr           = read_index[AW-1:0];
    wr_addr           = load_index[AW-1:0];
    ctrl              = '0;
    ctrl.wr_sel       = cfft_pkg::WR_SAMPLE;
    ctrl.inv          = inverse_mode;
    ctrl.out_zero     = out_zero;

    unique case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == cfft_pkg::CFG_POINTS_LOG2) points_log2_next = cfg_data;
          else inverse_mode_next = cfg_data[0];
          phase_next      = cfft_pkg::PH_LOADING;
          load_index_next = '0;
          read_index_next = '0;
        end else if (accept && func == cfft_pkg::FUNC_LOAD) begin
          if (phase == cfft_pkg::PH_LOADING && load_index < n_pts) begin
            ctrl.wr_en      = 1'b1;
            load_index_next = load_index + (AW+1)'(1);
            if (load_index_next >= n_pts) begin
              idx_next = '0;
              st0_next = '0;
              if (len_log2 == '0) begin
                phase_next      = cfft_pkg::PH_READY;
                read_index_next = '0;
              end else begin
                state_next = S_BR_A;
              end
            end
          end
        end else if (accept) begin
          result_valid_next = 1'b1;
          if (phase == cfft_pkg::PH_READY && read_index < n_pts) begin
            out_zero_next    = 1'b0;
            last_result_next = (read_index == n_pts - (AW+1)'(1));
            read_index_next  = read_index + (AW+1)'(1);
            if (read_index_next >= n_pts) begin
              phase_next      = cfft_pkg::PH_LOADING;
              load_index_next = '0;
              read_index_next = '0;
            end
          end else begin
            out_zero_next = 1'b1;
            status_next   = cfft_pkg::STATUS_NOT_READY;
          end
        end
      end
      S_BR_A: begin
        rd_addr = idx;
        if (rev > idx) state_next = S_BR_B;
        else if (idx == n_m1) begin
          idx_next   = '0;
          state_next = S_BF_A;
        end else idx_next = idx + AW'(1);
      end
      S_BR_B: begin
        rd_addr    = rev;
        ctrl.lat_a = 1'b1;
        state_next = S_BR_C;
      end
      S_BR_C: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = cfft_pkg::WR_DOUT;
        wr_addr     = idx;
        state_next  = S_BR_D;
      end
      S_BR_D: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = cfft_pkg::WR_OPA;
        wr_addr     = rev;
        if (idx == n_m1) begin
          idx_next   = '0;
          state_next = S_BF_A;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_BR_A;
        end
      end
      S_BF_A: begin
        rd_addr    = ia;
        state_next = S_BF_B;
      end
      S_BF_B: begin
        rd_addr    = ja;
        ctrl.lat_a = 1'b1;
        state_next = S_BF_C;
      end
      S_BF_C: begin
        ctrl.mul_en = 1'b1;
        state_next  = S_BF_D;
      end
      S_BF_D: begin
        ctrl.sum_en = 1'b1;
        state_next  = S_BF_E;
      end
      S_BF_E: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = cfft_pkg::WR_SUM_HI;
        wr_addr     = ia;
        state_next  = S_BF_F;
      end
      S_BF_F: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = cfft_pkg::WR_SUM_LO;
        wr_addr     = ja;
        state_next  = S_BF_A;
        if (idx == half_m1) begin
          idx_next = '0;
          if (st0 == len_log2 - LW'(1)) begin
            if (inverse_mode) state_next = S_SC_A;
            else begin
              state_next      = S_IDLE;
              phase_next      = cfft_pkg::PH_READY;
              read_index_next = '0;
            end
          end else st0_next = st0 + LW'(1);
        end else idx_next = idx + AW'(1);
      end
      S_SC_A: begin
        rd_addr    = idx;
        state_next = S_SC_B;
      end
      S_SC_B: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = cfft_pkg::WR_SCALED;
        wr_addr     = idx;
        if (idx == n_m1) begin
          state_next      = S_IDLE;
          phase_next      = cfft_pkg::PH_READY;
          read_index_next = '0;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_SC_A;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      points_log2  <= cfft_pkg::POINTS_LOG2_RESET;
      inverse_mode <= 1'b0;
      phase        <= cfft_pkg::PH_LOADING;
      load_index   <= '0;
      read_index   <= '0;
      idx          <= '0;
      st0          <= '0;
      result_valid <= 1'b0;
      last_result  <= 1'b0;
      status       <= cfft_pkg::STATUS_OK;
      out_zero     <= 1'b0;
    end else begin
      state        <= state_next;
      points_log2  <= points_log2_next;
      inverse_mode <= inverse_mode_next;
      phase        <= phase_next;
      load_index   <= load_index_next;
      read_index   <= read_index_next;
      idx          <= idx_next;
      st0          <= st0_next;
      result_valid <= result_valid_next;
      last_result  <= last_result_next;
      status       <= status_next;
      out_zero     <= out_zero_next;
    end
  end

endmodule

@@ rtl/complex_fft_radix2.sv @@
// Top level of the in-place radix-2 decimation-in-time complex FFT.
// Depends on cfft_pkg, cfft_ctrl, cfft_dp (and cfft_ram through cfft_dp).
`timescale 1ns / 1ps
// Use:
//  Items enter on start/func/sample_*; an item is taken on a clock edge with
//  start high, busy low and cfg_valid low. func = load stores one complex
//  sample; once 2^points_log2 samples are in, busy rises for the transform.
//  func = read returns one result: result_valid is high for exactly one cycle,
//  the cycle after the read is taken, with result_real/imag, last_result on
//  the final point and status; the receiver cannot stall, so results are
//  never held. A read before the transform is done answers status = 1.
//  Loads and reads can be accepted back to back while busy is low.
//  Transform, N = 2^L: a bit-reversal pass visits every index and swaps each
//  pair once, then N/2 * L butterflies each read, multiply, sum and write back
//  their two points in turn through the store's one read and one write port;
//  the inverse mode then adds a scaling pass over all N points.
//  Config: cfg_valid/cfg_ready, cfg_index 0 = points_log2, 1 = inverse_mode.
//  Any config write restarts the frame; stored data stay. cfg_ready is low
//  while busy. Reset (rst, synchronous) sets points_log2 = 10, forward mode
//  and an empty frame; the sample store holds no reset value.
module complex_fft_radix2 #(
  parameter int MAX_POINTS        = cfft_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH      = cfft_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_FRAC_BITS = cfft_pkg::TW_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   func,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_imag,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [cfft_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  output logic                                   result_valid,
  output logic signed [cfft_pkg::DATA_WIDTH-1:0] result_real,
  output logic signed [cfft_pkg::DATA_WIDTH-1:0] result_imag,
  output logic                                   last_result,
  output logic                                   status
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int LW  = $clog2(AW + 1);
  localparam int TWA = (AW > 1) ? AW - 1 : 1;

  cfft_pkg::dp_ctrl_t ctrl;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [TWA-1:0] tw_idx;
  logic [LW-1:0]  scale_shift;

  // registers are taken only while the sequencer is idle
  assign cfg_ready = !busy;

  cfft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .busy         (busy),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .last_result  (last_result),
    .status       (status),
    .ctrl         (ctrl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .tw_idx       (tw_idx),
    .scale_shift  (scale_shift)
  );

  // store, twiddles and butterfly arithmetic
  cfft_dp #(
    .MAX_POINTS        (MAX_POINTS),
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .tw_idx      (tw_idx),
    .scale_shift (scale_shift),
    .sample_real (sample_real),
    .sample_imag (sample_imag),
    .result_real (result_real),
    .result_imag (result_imag)
  );

endmodule
